// ===== rtl/core/pic_pkg.sv =====
package pic_pkg;

   localparam int NUM_LINES = 8;
   localparam int LINE_W    = $clog2(NUM_LINES);

   // Bit positions within the initialisation and operation command words.
   localparam int ICW1_IC4  = 0;
   localparam int ICW1_SNGL = 1;
   localparam int ICW4_UPM  = 0;
   localparam int ICW4_AEOI = 1;
   localparam int OCW2_EOI  = 5;
   localparam int OCW2_SL   = 6;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CHECK = 2'd2,
      FUNC_ACK   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      INIT_DONE = 3'd0,
      INIT_ICW1 = 3'd1,
      INIT_ICW2 = 3'd2,
      INIT_ICW3 = 3'd3,
      INIT_ICW4 = 3'd4
   } init_type;

   typedef struct packed {
      logic [1:0] func;
      logic       port_a0;
      logic [7:0] write_data;
      logic [7:0] request_lines;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       int_raised;
      logic       vector_valid;
      logic [7:0] vector;
   } rsp_type;

   typedef struct packed {
      logic              found;
      logic [LINE_W-1:0] idx;
   } lowest_type;

   // Lowest set bit of a line vector, which is also the highest priority line.
   function automatic lowest_type lowest_set(input logic [NUM_LINES-1:0] v);
      lowest_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r.found = 1'b1;
            r.idx   = LINE_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/pic_ifs.sv =====
interface pic_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       port_a0;
   logic [7:0] write_data;
   logic [7:0] request_lines;

   modport source (output valid, func, port_a0, write_data, request_lines, input ready);
   modport sink (input valid, func, port_a0, write_data, request_lines, output ready);
endinterface

interface pic_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       int_raised;
   logic       vector_valid;
   logic [7:0] vector;

   modport source (output valid, read_data, int_raised, vector_valid, vector, input ready);
   modport sink (input valid, read_data, int_raised, vector_valid, vector, output ready);
endinterface

// ===== rtl/core/pic_engine.sv =====
module pic_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  pic_pkg::req_type item,
   input  logic             is_master,
   output pic_pkg::rsp_type result
);

   pic_pkg::init_type init_step_ff, init_step_in;
   logic [7:0] icw_one_ff, icw_one_in;
   logic [7:0] icw_two_ff, icw_two_in;
   logic [7:0] icw_three_ff, icw_three_in;
   logic [7:0] icw_four_ff, icw_four_in;
   logic [pic_pkg::NUM_LINES-1:0] irr_ff, irr_in;
   logic [pic_pkg::NUM_LINES-1:0] isr_ff, isr_in;
   logic [pic_pkg::NUM_LINES-1:0] imr_ff, imr_in;

   pic_pkg::lowest_type isr_low;
   pic_pkg::lowest_type req_low;
   pic_pkg::lowest_type irr_low;
   logic [pic_pkg::NUM_LINES-1:0] upto;
   logic [7:0] base;

   always_comb begin
      isr_low = pic_pkg::lowest_set(isr_ff);
      req_low = pic_pkg::lowest_set(imr_ff & item.request_lines);
      irr_low = pic_pkg::lowest_set(irr_ff);
      // Lines of equal or higher priority than the chosen one.
      for (int k = 0; k < pic_pkg::NUM_LINES; k++) begin
         upto[k] = (pic_pkg::LINE_W'(k) <= req_low.idx);
      end
      if (icw_four_ff[pic_pkg::ICW4_UPM]) begin
         base = {icw_two_ff[7:3], 3'b000};
      end else begin
         base = {5'b00000, icw_one_ff[7:5]} + {2'b00, icw_two_ff[2:0], 3'b000};
      end
   end

   always_comb begin
      init_step_in = init_step_ff;
      icw_one_in   = icw_one_ff;
      icw_two_in   = icw_two_ff;
      icw_three_in = icw_three_ff;
      icw_four_in  = icw_four_ff;
      irr_in       = irr_ff;
      isr_in       = isr_ff;
      imr_in       = imr_ff;
      result       = '0;

      case (pic_pkg::func_type'(item.func))
         pic_pkg::FUNC_WRITE: begin
            if (!item.port_a0) begin
               if (init_step_ff != pic_pkg::INIT_DONE) begin
                  icw_one_in   = item.write_data;
                  init_step_in = pic_pkg::INIT_ICW2;
               end else if (item.write_data[pic_pkg::OCW2_EOI]) begin
                  if (item.write_data[pic_pkg::OCW2_SL]) begin
                     isr_in[item.write_data[pic_pkg::LINE_W-1:0]] = 1'b0;
                  end else if (isr_low.found) begin
                     isr_in[isr_low.idx] = 1'b0;
                  end
               end
            end else begin
               case (init_step_ff)
                  pic_pkg::INIT_DONE: begin
                     imr_in = ~item.write_data;
                  end
                  pic_pkg::INIT_ICW2: begin
                     icw_two_in   = item.write_data;
                     init_step_in = icw_one_ff[pic_pkg::ICW1_SNGL] ?
                                    pic_pkg::INIT_DONE : pic_pkg::INIT_ICW3;
                  end
                  pic_pkg::INIT_ICW3: begin
                     icw_three_in = item.write_data;
                     init_step_in = icw_one_ff[pic_pkg::ICW1_IC4] ?
                                    pic_pkg::INIT_ICW4 : pic_pkg::INIT_DONE;
                  end
                  pic_pkg::INIT_ICW4: begin
                     icw_four_in  = item.write_data;
                     init_step_in = pic_pkg::INIT_DONE;
                  end
                  default: begin
                     init_step_in = pic_pkg::INIT_DONE;
                  end
               endcase
            end
         end
         pic_pkg::FUNC_READ: begin
            if (item.port_a0) begin
               result.read_data = ~imr_ff;
            end
         end
         pic_pkg::FUNC_CHECK: begin
            if (init_step_ff == pic_pkg::INIT_DONE && irr_ff == '0 && req_low.found
                && (isr_ff & upto) == '0) begin
               irr_in              = '0;
               irr_in[req_low.idx] = 1'b1;
               result.int_raised   = 1'b1;
            end
         end
         pic_pkg::FUNC_ACK: begin
            if (irr_low.found) begin
               if (!icw_four_ff[pic_pkg::ICW4_AEOI]) begin
                  isr_in[irr_low.idx] = 1'b1;
               end
               irr_in[irr_low.idx] = 1'b0;
               // A master's cascade line hands the vector over to the slave.
               if (!(!icw_one_ff[pic_pkg::ICW1_SNGL] && is_master
                     && icw_three_ff[irr_low.idx])) begin
                  result.vector_valid = 1'b1;
                  result.vector       = base + {5'b00000, irr_low.idx};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_step_ff <= pic_pkg::INIT_ICW1;
         icw_one_ff   <= '0;
         icw_two_ff   <= '0;
         icw_three_ff <= '0;
         icw_four_ff  <= '0;
         irr_ff       <= '0;
         isr_ff       <= '0;
         imr_ff       <= '0;
      end else if (fire) begin
         init_step_ff <= init_step_in;
         icw_one_ff   <= icw_one_in;
         icw_two_ff   <= icw_two_in;
         icw_three_ff <= icw_three_in;
         icw_four_ff  <= icw_four_in;
         irr_ff       <= irr_in;
         isr_ff       <= isr_in;
         imr_ff       <= imr_in;
      end
   end

endmodule

// ===== rtl/core/interrupt_controller_8259.sv =====
// Channel   Direction  Contents
// req_chan  in         func, port_a0, write_data, request_lines
// rsp_chan  out        read_data, int_raised, vector_valid, vector
// csr_*     in         is_master (write enable and one data bit)
//
// Each request is held in the input register and then passes to the result
// register, from which its response is offered on rsp_chan.
// One request is taken per cycle while the response side keeps up; the limit
// is the single pass through the controller state between the two registers.
// Reset is synchronous and puts the controller back to awaiting ICW1 with
// is_master set. A stalled response holds the result register, and the input
// register then fills and lowers req_chan.ready.
module interrupt_controller_8259 (
   input  logic clock,
   input  logic reset,
   pic_req_if.sink   req_chan,
   pic_rsp_if.source rsp_chan,
   input  logic csr_write_enable,
   input  logic csr_write_data
);

   logic             is_master_ff;
   logic             in_valid_ff;
   pic_pkg::req_type in_item_ff;
   logic             out_valid_ff;
   pic_pkg::rsp_type out_item_ff;
   pic_pkg::rsp_type result;
   logic             advance;

   // The held request moves on whenever the result register is free or is
   // being emptied in this cycle; the controller state updates at that edge.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_master_ff <= 1'b1;
      end else if (csr_write_enable) begin
         is_master_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.func          <= req_chan.func;
         in_item_ff.port_a0       <= req_chan.port_a0;
         in_item_ff.write_data    <= req_chan.write_data;
         in_item_ff.request_lines <= req_chan.request_lines;
      end
   end

   pic_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_item_ff),
      .is_master (is_master_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.read_data    = out_item_ff.read_data;
   assign rsp_chan.int_raised   = out_item_ff.int_raised;
   assign rsp_chan.vector_valid = out_item_ff.vector_valid;
   assign rsp_chan.vector       = out_item_ff.vector;

endmodule
